[sv/sfg_pkg.sv]
// Shared types and constants for the shingle fingerprint generator.
// No dependencies; imported by every sfg module and the top level.
package sfg_pkg;

   localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME  = 32'd16777619;
   localparam logic [31:0] POLY_BASE  = 32'd16777619;

   localparam int          MAX_WINDOW_DEFAULT = 8;
   localparam int          QUEUE_DEPTH        = 4;
   localparam int          CSR_W              = 4;
   localparam logic [CSR_W-1:0] WINDOW_RESET  = 4'd5;

   // One finished token handed from front to back.
   typedef struct packed {
      logic [31:0] word_hash;
      logic        doc_end;
   } token_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_CALC,
      BACK_OUT
   } back_state_type;

endpackage

[sv/sfg_front.sv]
// Front end: accepts byte requests and folds them into the FNV-1a token hash.
// Pushes each finished token hash into the token queue. Uses sfg_pkg.
module sfg_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic                req_byte_valid,
   input  logic                req_token_end,
   input  logic                req_doc_end,
   input  logic                queue_full,
   output logic                push,
   output sfg_pkg::token_type  push_token
);
   import sfg_pkg::*;

   logic [31:0] byte_hash_ff;
   logic [31:0] byte_hash_in;
   logic [31:0] folded;
   logic        accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      folded = byte_hash_ff;
      if (req_byte_valid) begin
         folded = 32'((byte_hash_ff ^ {24'd0, req_data_byte}) * FNV_PRIME);
      end
      push_token.word_hash = (folded == 32'd0) ? 32'd1 : folded;
      push_token.doc_end   = req_doc_end;
      push                 = accept && req_token_end;
      byte_hash_in         = byte_hash_ff;
      if (accept) begin
         byte_hash_in = req_token_end ? FNV_OFFSET : folded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_hash_ff <= FNV_OFFSET;
      end else begin
         byte_hash_ff <= byte_hash_in;
      end
   end

endmodule

[sv/sfg_queue.sv]
// Small FIFO of finished tokens between the front and back ends.
// Uses sfg_pkg for the entry type.
module sfg_queue #(
   parameter int DEPTH = sfg_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sfg_pkg::token_type  push_token,
   input  logic                pop,
   output sfg_pkg::token_type  head_token,
   output logic                full,
   output logic                empty
);
   import sfg_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   token_type         entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign empty      = (count_ff == '0);
   assign head_token = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_token;
      end
   end

endmodule

[sv/sfg_back.sv]
// Back end: token hash window, iterative polynomial fingerprint and result register.
// Holds the window size register. Uses sfg_pkg.
module sfg_back #(
   parameter int MAX_WINDOW = sfg_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic [sfg_pkg::CSR_W-1:0]  csr_write_data,
   input  logic                       queue_empty,
   input  sfg_pkg::token_type         head_token,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [31:0]                rsp_fingerprint,
   output logic                       rsp_fingerprint_valid,
   output logic [31:0]                rsp_word_hash,
   output logic                       rsp_doc_last
);
   import sfg_pkg::*;

   localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);

   back_state_type     state_ff, state_in;
   logic [CSR_W-1:0]   csr_ff;
   logic [31:0]        window_ff [MAX_WINDOW];
   logic [CNT_W-1:0]   seen_ff, seen_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [31:0]        acc_ff, acc_in;
   logic               ready_ff, ready_in;
   logic [31:0]        word_ff;
   logic               doc_ff;
   logic               shift;
   logic [4:0]         csr_wide;
   logic [4:0]         eff_wide;
   logic [CNT_W-1:0]   eff_window;
   logic [31:0]        product;
   logic               out_free;
   logic               load_rsp;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_fp_ff;
   logic               rsp_fpv_ff;
   logic [31:0]        rsp_word_ff;
   logic               rsp_doc_ff;

   // Window size: zero counts as one, anything above the window depth saturates.
   always_comb begin
      csr_wide = {1'b0, csr_ff};
      if (csr_wide == 5'd0) begin
         eff_wide = 5'd1;
      end else if (csr_wide > 5'(MAX_WINDOW)) begin
         eff_wide = 5'(MAX_WINDOW);
      end else begin
         eff_wide = csr_wide;
      end
      eff_window = CNT_W'(eff_wide);
   end

   assign product  = 32'(acc_ff * POLY_BASE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      seen_in      = seen_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      ready_in     = ready_ff;
      pop          = 1'b0;
      shift        = 1'b0;
      load_rsp     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         BACK_IDLE: begin
            if (!queue_empty) begin
               pop   = 1'b1;
               shift = 1'b1;
               if (seen_ff != CNT_W'(MAX_WINDOW)) begin
                  seen_in = CNT_W'(seen_ff + 1'b1);
               end
               ready_in = (seen_in >= eff_window);
               acc_in   = '0;
               idx_in   = IDX_W'(eff_window - 1'b1);
               state_in = ready_in ? BACK_CALC : BACK_OUT;
            end
         end
         BACK_CALC: begin
            // Horner step, oldest hash first.
            acc_in = product + window_ff[idx_ff];
            if (idx_ff == '0) begin
               state_in = BACK_OUT;
            end else begin
               idx_in = IDX_W'(idx_ff - 1'b1);
            end
         end
         BACK_OUT: begin
            if (out_free) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = BACK_IDLE;
               if (doc_ff) begin
                  seen_in = '0;
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         csr_ff       <= WINDOW_RESET;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            csr_ff <= csr_write_data;
         end
      end
   end

   // Entries past the fill count are never read, so the window needs no clear.
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      acc_ff   <= acc_in;
      ready_ff <= ready_in;
      if (shift) begin
         window_ff[0] <= head_token.word_hash;
         for (int i = 1; i < MAX_WINDOW; i++) begin
            window_ff[i] <= window_ff[i-1];
         end
         word_ff <= head_token.word_hash;
         doc_ff  <= head_token.doc_end;
      end
      if (load_rsp) begin
         rsp_fp_ff   <= !ready_ff ? 32'd0 : ((acc_ff == 32'd0) ? 32'd1 : acc_ff);
         rsp_fpv_ff  <= ready_ff;
         rsp_word_ff <= word_ff;
         rsp_doc_ff  <= doc_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_fingerprint       = rsp_fp_ff;
   assign rsp_fingerprint_valid = rsp_fpv_ff;
   assign rsp_word_hash         = rsp_word_ff;
   assign rsp_doc_last          = rsp_doc_ff;

endmodule

[sv/shingle_fingerprint_generator.sv]
// Path: a token-end request goes into the token queue, is popped by the back end, runs
// through the Horner steps when the window is full, then loads the response register.
// Throughput: one byte request per cycle while req_stall is low; the back end pops no new
// token until the last response is loaded (one Horner step per cycle through a single
// multiplier); a 4-entry token queue absorbs bursts. Synchronous active-high reset:
// hash = offset basis, window empty, window size 5, queue and response register empty.
module shingle_fingerprint_generator #(
   parameter int MAX_WINDOW = sfg_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic [sfg_pkg::CSR_W-1:0]  csr_write_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_data_byte,
   input  logic                       req_byte_valid,
   input  logic                       req_token_end,
   input  logic                       req_doc_end,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [31:0]                rsp_fingerprint,
   output logic                       rsp_fingerprint_valid,
   output logic [31:0]                rsp_word_hash,
   output logic                       rsp_doc_last
);
   import sfg_pkg::*;

   token_type push_token;
   token_type head_token;
   logic      push;
   logic      pop;
   logic      queue_full;
   logic      queue_empty;

   sfg_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_byte_valid (req_byte_valid),
      .req_token_end  (req_token_end),
      .req_doc_end    (req_doc_end),
      .queue_full     (queue_full),
      .push           (push),
      .push_token     (push_token)
   );

   sfg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .pop        (pop),
      .head_token (head_token),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   sfg_back #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_en          (csr_write_en),
      .csr_write_data        (csr_write_data),
      .queue_empty           (queue_empty),
      .head_token            (head_token),
      .pop                   (pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_fingerprint       (rsp_fingerprint),
      .rsp_fingerprint_valid (rsp_fingerprint_valid),
      .rsp_word_hash         (rsp_word_hash),
      .rsp_doc_last          (rsp_doc_last)
   );

endmodule
